// ===== rtl/core/huf_pkg.sv =====
// Shared types and codes for the Huffman bit decoder.
// No dependencies; used by huf_match and huffman_bit_decoder_unit.
package huf_pkg;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_LEFTOVER = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    // One code-table entry as held in the table RAM
    typedef struct packed {
        logic [7:0]  symbol;
        logic [31:0] code;
        logic [5:0]  length;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SCAN,
        ST_FINISH,
        ST_FLUSH
    } state_t;

endpackage

// ===== rtl/core/huf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module huf_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/huf_match.sv =====
// Shared compare unit: checks one table entry against the accumulated code.
// Depends on huf_pkg (entry_t).
module huf_match #(
    parameter int MAX_CODE_BITS = 32
) (
    input  huf_pkg::entry_t                    entry,
    input  logic                               entry_valid,
    input  logic [MAX_CODE_BITS-1:0]           pend_bits,
    input  logic [$clog2(MAX_CODE_BITS+1)-1:0] pend_len,
    output logic                               hit
);

    logic [63:0] mask;
    logic [63:0] code_ext;
    logic [63:0] pend_ext;
    logic        len_ok;

    always_comb
    begin
        mask     = (64'd1 << entry.length) - 64'd1;
        code_ext = 64'(entry.code) & mask;
        // pending bits above the current length are always zero
        pend_ext = 64'(pend_bits);
        len_ok   = (entry.length != 6'd0)
                && (8'(entry.length) <= 8'(MAX_CODE_BITS))
                && (8'(entry.length) == 8'(pend_len));
        hit      = entry_valid && len_ok && (pend_ext == code_ext);
    end

endmodule

// ===== rtl/core/huffman_bit_decoder_unit.sv =====
// Top level of the Huffman bit decoder: sequencer, valid map, result buffer.
// Depends on huf_pkg, huf_ram and huf_match.
//
// A load item (func 0) writes one table slot in the cycle it is accepted and
// leaves busy low. A decode item (func 1) shifts its bits in one at a time;
// after each bit one compare unit walks the table RAM slot by slot, one slot
// per cycle, stopping at the first match. Each bit takes a shift step and a
// table scan (cut short on a hit); the item ends with finish and flush steps
// before busy drops. Each result is shown for exactly one cycle with
// result_strobe high and must be taken then; the receiver cannot stall. The
// newest result is held back one step so that last can be marked on the final
// result of the item. The valid map clears at reset.
module huffman_bit_decoder_unit #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  entry_symbol,
    input  logic [31:0] entry_code,
    input  logic [5:0]  entry_length,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  bit_count,
    input  logic        end_of_stream,
    output logic        result_strobe,
    output logic [7:0]  symbol,
    output logic        symbol_valid,
    output logic [1:0]  code_error,
    output logic        last
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    huf_pkg::state_t state_reg, state_next;

    logic [MAX_CODE_BITS-1:0] pend_bits_reg, pend_bits_next;
    logic [LEN_W-1:0]         pend_len_reg, pend_len_next;
    logic [7:0]               byte_reg, byte_next;
    logic [3:0]               count_reg, count_next;
    logic                     eos_reg, eos_next;
    logic [CNT_W-1:0]         scan_cnt_reg, scan_cnt_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic                     hold_vld_reg, hold_vld_next;
    logic [7:0]               hold_sym_reg, hold_sym_next;
    logic                     hold_sv_reg, hold_sv_next;
    logic [1:0]               hold_err_reg, hold_err_next;

    logic                     strobe_reg, strobe_next;
    logic [7:0]               symbol_reg, symbol_next;
    logic                     sv_reg, sv_next;
    logic [1:0]               err_reg, err_next;
    logic                     last_reg, last_next;

    logic                     accept;
    logic                     load_we;
    logic                     issue;
    logic                     flush;
    logic                     new_res;
    logic [7:0]               new_sym;
    logic                     new_sv;
    logic [1:0]               new_err;
    logic                     hit;
    logic                     too_long;
    logic [$bits(huf_pkg::entry_t)-1:0] rd_data;
    huf_pkg::entry_t          wr_entry;
    huf_pkg::entry_t          rd_entry;

    assign busy     = (state_reg != huf_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign load_we  = accept && (func == huf_pkg::FUNC_LOAD)
                   && (32'(entry_index) < TABLE_ENTRIES);
    assign too_long = (pend_len_reg >= LEN_W'(MAX_CODE_BITS));

    assign wr_entry = '{symbol: entry_symbol, code: entry_code, length: entry_length};
    assign rd_entry = huf_pkg::entry_t'(rd_data);

    huf_ram #(
        .WIDTH ($bits(huf_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (entry_index[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    huf_match #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_match (
        .entry       (rd_entry),
        .entry_valid (valid_reg[cmp_idx_reg]),
        .pend_bits   (pend_bits_reg),
        .pend_len    (pend_len_reg),
        .hit         (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= huf_pkg::ST_IDLE;
            pend_bits_reg <= '0;
            pend_len_reg  <= '0;
            count_reg     <= '0;
            eos_reg       <= 1'b0;
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            hold_vld_reg  <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_bits_reg <= pend_bits_next;
            pend_len_reg  <= pend_len_next;
            count_reg     <= count_next;
            eos_reg       <= eos_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            hold_vld_reg  <= hold_vld_next;
            strobe_reg    <= strobe_next;
            if (load_we)
            begin
                valid_reg[entry_index[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        cmp_idx_reg  <= cmp_idx_next;
        hold_sym_reg <= hold_sym_next;
        hold_sv_reg  <= hold_sv_next;
        hold_err_reg <= hold_err_next;
        symbol_reg   <= symbol_next;
        sv_reg       <= sv_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        pend_bits_next = pend_bits_reg;
        pend_len_next  = pend_len_reg;
        byte_next      = byte_reg;
        count_next     = count_reg;
        eos_next       = eos_reg;
        scan_cnt_next  = scan_cnt_reg;
        issue          = 1'b0;
        flush          = 1'b0;
        new_res        = 1'b0;
        new_sym        = 8'd0;
        new_sv         = 1'b0;
        new_err        = huf_pkg::ERR_NONE;

        unique case (state_reg)
            huf_pkg::ST_IDLE:
            begin
                if (accept && (func == huf_pkg::FUNC_DECODE))
                begin
                    byte_next  = data_byte;
                    count_next = (bit_count > 4'd8) ? 4'd8 : bit_count;
                    eos_next   = end_of_stream;
                    state_next = (bit_count == 4'd0) ? huf_pkg::ST_FINISH
                                                     : huf_pkg::ST_SHIFT;
                end
            end
            huf_pkg::ST_SHIFT:
            begin
                pend_bits_next = {pend_bits_reg[MAX_CODE_BITS-2:0], byte_reg[7]};
                pend_len_next  = pend_len_reg + LEN_W'(1);
                byte_next      = {byte_reg[6:0], 1'b0};
                count_next     = count_reg - 4'd1;
                scan_cnt_next  = '0;
                state_next     = huf_pkg::ST_SCAN;
            end
            huf_pkg::ST_SCAN:
            begin
                if (cmp_vld_reg && hit)
                begin
                    new_res        = 1'b1;
                    new_sym        = rd_entry.symbol;
                    new_sv         = 1'b1;
                    pend_bits_next = '0;
                    pend_len_next  = '0;
                    state_next     = (count_reg != 4'd0) ? huf_pkg::ST_SHIFT
                                                         : huf_pkg::ST_FINISH;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1)))
                begin
                    // whole table missed
                    if (too_long)
                    begin
                        new_res        = 1'b1;
                        new_err        = huf_pkg::ERR_TOO_LONG;
                        pend_bits_next = '0;
                        pend_len_next  = '0;
                    end
                    state_next = (count_reg != 4'd0) ? huf_pkg::ST_SHIFT
                                                     : huf_pkg::ST_FINISH;
                end
                else if (scan_cnt_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    issue         = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end
            huf_pkg::ST_FINISH:
            begin
                if (eos_reg && (pend_len_reg != '0))
                begin
                    new_res        = 1'b1;
                    new_err        = huf_pkg::ERR_LEFTOVER;
                    pend_bits_next = '0;
                    pend_len_next  = '0;
                end
                state_next = huf_pkg::ST_FLUSH;
            end
            huf_pkg::ST_FLUSH:
            begin
                flush      = 1'b1;
                state_next = huf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = huf_pkg::ST_IDLE;
            end
        endcase
    end

    assign cmp_vld_next = issue;
    assign cmp_idx_next = issue ? scan_cnt_reg[IDX_W-1:0] : cmp_idx_reg;

    // Result buffer: hold the newest result until the next one or item end
    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        hold_sym_next = hold_sym_reg;
        hold_sv_next  = hold_sv_reg;
        hold_err_next = hold_err_reg;
        strobe_next   = 1'b0;
        symbol_next   = hold_sym_reg;
        sv_next       = hold_sv_reg;
        err_next      = hold_err_reg;
        last_next     = 1'b0;

        if (new_res)
        begin
            strobe_next   = hold_vld_reg;
            hold_vld_next = 1'b1;
            hold_sym_next = new_sym;
            hold_sv_next  = new_sv;
            hold_err_next = new_err;
        end
        else if (flush && hold_vld_reg)
        begin
            strobe_next   = 1'b1;
            last_next     = 1'b1;
            hold_vld_next = 1'b0;
        end
    end

    assign result_strobe = strobe_reg;
    assign symbol        = symbol_reg;
    assign symbol_valid  = sv_reg;
    assign code_error    = err_reg;
    assign last          = last_reg;

    a_sym_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && symbol_valid |-> code_error == huf_pkg::ERR_NONE)
        else $error("decoded symbol reported with an error code");

    a_err_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !symbol_valid |-> symbol == 8'd0
            && code_error != huf_pkg::ERR_NONE)
        else $error("error result carries a symbol or no error code");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !cmp_vld_reg && !hold_vld_reg)
        else $error("scan or held result left over while idle");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_len_reg <= LEN_W'(MAX_CODE_BITS))
        else $error("accumulated code longer than the maximum");

    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == huf_pkg::FUNC_DECODE |=> busy)
        else $error("decode transfer did not raise busy");

endmodule
